// ===== rtl/su8_pkg.sv =====
// Shared types, codes and helpers for the strict UTF-8 decoder.
package su8_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [1:0] StChar  = 2'd0;
  localparam logic [1:0] StError = 2'd1;
  localparam logic [1:0] StEnd   = 2'd2;

  localparam logic [20:0] CpMin2   = 21'd128;
  localparam logic [20:0] CpMin3   = 21'd2048;
  localparam logic [20:0] CpMin4   = 21'd65536;
  localparam logic [20:0] CpSurLo  = 21'd55296;
  localparam logic [20:0] CpSurHi  = 21'd57343;
  localparam logic [20:0] CpMax    = 21'd1114111;

  typedef enum logic [2:0] {
    CLS_ASCII   = 3'd0,
    CLS_LEAD2   = 3'd1,
    CLS_LEAD3   = 3'd2,
    CLS_LEAD4   = 3'd3,
    CLS_CONT    = 3'd4,
    CLS_INVALID = 3'd5,
    CLS_EOS     = 3'd6
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [6:0] bits;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic value_ok(input logic [1:0] len, input logic [20:0] v);
    logic ok;
    ok = 1'b0;
    case (len)
      2'd1:    ok = (v >= CpMin2);
      2'd2:    ok = (v >= CpMin3) && ((v < CpSurLo) || (v > CpSurHi));
      2'd3:    ok = (v >= CpMin4) && (v <= CpMax);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/su8_front.sv =====
// Front end: accept bytes, classify them and push them into the queue.
module su8_front import su8_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  qstat_t     qstat_i,
  output logic       push_o,
  output qent_t      ent_o
);

  cls_e cls;

  always_comb begin
    cls = CLS_INVALID;
    if (end_of_stream_i) begin
      cls = CLS_EOS;
    end else begin
      case (data_byte_i) inside
        8'b0???????: cls = CLS_ASCII;
        8'b10??????: cls = CLS_CONT;
        8'b110?????: cls = CLS_LEAD2;
        8'b1110????: cls = CLS_LEAD3;
        8'b11110???: cls = CLS_LEAD4;
        default:     cls = CLS_INVALID;
      endcase
    end
  end

  assign in_ready_o  = !qstat_i.full;
  assign push_o      = in_valid_i && !qstat_i.full;
  assign ent_o.cls   = cls;
  assign ent_o.bits  = data_byte_i[6:0];

endmodule

// ===== rtl/su8_queue.sv =====
// Short queue of classified words between front and back.
module su8_queue import su8_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qent_t  ent_i,
  input  logic   pop_i,
  output qent_t  ent_o,
  output qstat_t qstat_o
);

  qent_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= ent_i;
    end
  end

  assign ent_o         = mem_q[rptr_q];
  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/su8_back.sv =====
// Back end: run the sequence state and drive the result register.
module su8_back import su8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qent_t       ent_i,
  input  qstat_t      qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic [1:0]  status_o
);

  logic [1:0]  rem_q, rem_d;
  logic [1:0]  len_q, len_d;
  logic [20:0] pv_q, pv_d;
  logic        bad_q, bad_d;
  logic        ov_q, ov_d;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  st_q, st_d;
  logic        emit;
  logic [20:0] emit_cp;
  logic [1:0]  emit_st;
  logic [20:0] pv_next;
  logic        bad_next;
  logic [1:0]  rem_next;

  assign pop_o = !qstat_i.empty && (!ov_q || out_ready_i);

  always_comb begin
    rem_d    = rem_q;
    len_d    = len_q;
    pv_d     = pv_q;
    bad_d    = bad_q;
    emit     = 1'b0;
    emit_cp  = '0;
    emit_st  = StChar;
    pv_next  = {pv_q[14:0], ent_i.bits[5:0]};
    bad_next = bad_q || (ent_i.cls != CLS_CONT);
    rem_next = rem_q - 1'b1;
    if (pop_o) begin
      if (ent_i.cls == CLS_EOS) begin
        emit = 1'b1;
        if (rem_q != '0) begin
          emit_st = StError;
          rem_d   = '0;
          len_d   = '0;
          pv_d    = '0;
          bad_d   = 1'b0;
        end else begin
          emit_st = StEnd;
        end
      end else if (rem_q == '0) begin
        case (ent_i.cls)
          CLS_ASCII: begin
            emit    = 1'b1;
            emit_cp = {14'd0, ent_i.bits};
          end
          CLS_LEAD2: begin
            len_d = 2'd1;
            rem_d = 2'd1;
            pv_d  = {16'd0, ent_i.bits[4:0]};
            bad_d = 1'b0;
          end
          CLS_LEAD3: begin
            len_d = 2'd2;
            rem_d = 2'd2;
            pv_d  = {17'd0, ent_i.bits[3:0]};
            bad_d = 1'b0;
          end
          CLS_LEAD4: begin
            len_d = 2'd3;
            rem_d = 2'd3;
            pv_d  = {18'd0, ent_i.bits[2:0]};
            bad_d = 1'b0;
          end
          default: begin
            emit    = 1'b1;
            emit_st = StError;
          end
        endcase
      end else if (rem_next != '0) begin
        rem_d = rem_next;
        pv_d  = pv_next;
        bad_d = bad_next;
      end else begin
        emit = 1'b1;
        if (!bad_next && value_ok(len_q, pv_next)) begin
          emit_cp = pv_next;
        end else begin
          emit_st = StError;
        end
        rem_d = '0;
        len_d = '0;
        pv_d  = '0;
        bad_d = 1'b0;
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    cp_d = cp_q;
    st_d = st_q;
    if (emit) begin
      ov_d = 1'b1;
      cp_d = emit_cp;
      st_d = emit_st;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      len_q <= '0;
      pv_q  <= '0;
      bad_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      len_q <= len_d;
      pv_q  <= pv_d;
      bad_q <= bad_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
    st_q <= st_d;
  end

  assign out_valid_o  = ov_q;
  assign code_point_o = cp_q;
  assign status_o     = st_q;

endmodule

// ===== rtl/strict_utf8_decoder_top.sv =====
// Top level of the strict UTF-8 decoder.
// Takes one byte (or an end-of-stream marker) per clock and keeps that rate
// indefinitely while the result side is ready. A word enters a two-entry
// queue at acceptance; the back end takes one queued word per cycle while the
// result register is empty or being read, and registers at most one result for
// it; the word completing a result passes the queue, then the result register.
// The queue lets input flow on for two words while the result register is
// stalled. Status 0 carries a code point, 1 marks an encoding error, 2 end of stream.
module strict_utf8_decoder_top import su8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic [1:0]  status_o
);

  qstat_t qstat;
  qent_t  push_ent;
  qent_t  head_ent;
  logic   push;
  logic   pop;

  su8_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .ent_o           (push_ent)
  );

  su8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (push_ent),
    .pop_i   (pop),
    .ent_o   (head_ent),
    .qstat_o (qstat)
  );

  su8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_i        (head_ent),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .status_o     (status_o)
  );

  a_cp_zero_unless_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StChar) |-> code_point_o == '0)
    else $error("code point not zero on error or end result");

  a_char_is_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StChar) |->
      (code_point_o <= CpMax) && ((code_point_o < CpSurLo) || (code_point_o > CpSurHi)))
    else $error("decoded value is not a Unicode scalar value");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StChar) || (status_o == StError) || (status_o == StEnd))
    else $error("undefined status code");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.empty |-> !pop)
    else $error("back end consumed from an empty queue");

endmodule

// ===== tb/sv/strict_utf8_decoder_top_test.sv =====
// Self-checking testbench for the strict UTF-8 decoder: directed, back-pressure and random tests.
module strict_utf8_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import su8_pkg::*;

  localparam int TotalWords = 1200;
  localparam int LongHold   = 300;
  localparam int IdleLimit  = 5000;
  localparam int TailCycles = 20;

  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  st;
  } char_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_point;
  logic [1:0]  status;

  logic [1:0]  pend_bytes = '0;
  logic [1:0]  seq_conts = '0;
  logic [20:0] gathered = '0;
  logic        seq_broken = 1'b0;

  char_result_t expected_chars[$];
  int          words_sent = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic        long_hold_req = 1'b0;

  strict_utf8_decoder_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_stream_i(end_of_stream),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .code_point_o   (code_point),
    .status_o       (status)
  );

  always #5 clk = ~clk;

  task automatic drop_sequence();
    pend_bytes = '0;
    seq_conts  = '0;
    gathered   = '0;
    seq_broken = 1'b0;
  endtask

  task automatic decode_word(input logic [7:0] b, input logic eos);
    char_result_t r;
    logic ok;
    r.cp = '0;
    r.st = StError;
    ok = 1'b0;
    if (eos) begin
      r.st = (pend_bytes != 0) ? StError : StEnd;
      drop_sequence();
      expected_chars.push_back(r);
      return;
    end
    if (pend_bytes == 0) begin
      case (b) inside
        8'b0???????: begin
          r.cp = {13'd0, b};
          r.st = StChar;
          expected_chars.push_back(r);
        end
        8'b110?????: begin
          seq_conts = 2'd1;
          gathered  = {16'd0, b[4:0]};
        end
        8'b1110????: begin
          seq_conts = 2'd2;
          gathered  = {17'd0, b[3:0]};
        end
        8'b11110???: begin
          seq_conts = 2'd3;
          gathered  = {18'd0, b[2:0]};
        end
        default: expected_chars.push_back(r);
      endcase
      pend_bytes = seq_conts;
      seq_broken = 1'b0;
      return;
    end
    if (b[7:6] != 2'b10) seq_broken = 1'b1;
    gathered = {gathered[14:0], b[5:0]};
    pend_bytes = pend_bytes - 2'd1;
    if (pend_bytes != 0) return;
    case (seq_conts)
      2'd1: ok = gathered >= CpMin2;
      2'd2: ok = gathered >= CpMin3 && (gathered < CpSurLo || gathered > CpSurHi);
      2'd3: ok = gathered >= CpMin4 && gathered <= CpMax;
      default: ok = 1'b0;
    endcase
    if (ok && !seq_broken) begin
      r.cp = gathered;
      r.st = StChar;
    end
    drop_sequence();
    expected_chars.push_back(r);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    decode_word(b, eos);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_code_point(input logic [20:0] cp, input int conts);
    case (conts)
      0: send_word({1'b0, cp[6:0]}, 1'b0);
      1: begin
        send_word({3'b110, cp[10:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, 1'b0);
      end
      2: begin
        send_word({4'b1110, cp[15:12]}, 1'b0);
        send_word({2'b10, cp[11:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, 1'b0);
      end
      default: begin
        send_word({5'b11110, cp[20:18]}, 1'b0);
        send_word({2'b10, cp[17:12]}, 1'b0);
        send_word({2'b10, cp[11:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, 1'b0);
      end
    endcase
  endtask

  task automatic send_random_unit();
    logic [20:0] edges[14];
    logic [20:0] cp;
    logic [7:0]  b;
    int pick, conts, cut;
    edges = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hD800,
              21'hDFFF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h110000,
              21'h1FFFFF};
    pick  = $urandom_range(0, 99);
    conts = $urandom_range(0, 3);
    if (pick < 45) begin
      case (conts)
        0: cp = 21'($urandom_range(0, 127));
        1: cp = 21'($urandom_range(128, 2047));
        2: do cp = 21'($urandom_range(2048, 65535)); while (cp >= CpSurLo && cp <= CpSurHi);
        default: cp = 21'($urandom_range(65536, 1114111));
      endcase
      send_code_point(cp, conts);
    end else if (pick < 55) begin
      send_code_point(edges[$urandom_range(0, 13)], conts);
    end else if (pick < 70) begin
      cp = 21'($urandom);
      send_code_point(cp, conts);
    end else if (pick < 82) begin
      conts = $urandom_range(1, 3);
      b = 8'($urandom);
      case (conts)
        1: send_word({3'b110, b[4:0]}, 1'b0);
        2: send_word({4'b1110, b[3:0]}, 1'b0);
        default: send_word({5'b11110, b[2:0]}, 1'b0);
      endcase
      cut = $urandom_range(0, 3) == 0 ? $urandom_range(0, conts - 1) : conts;
      for (int k = 0; k < cut; k++) begin
        b = 8'($urandom);
        if ($urandom_range(0, 2) != 0) b[7:6] = 2'b10;
        send_word(b, 1'b0);
      end
      if (cut < conts) send_word(8'($urandom), 1'b1);
    end else if (pick < 95) begin
      send_word(8'($urandom), 1'b0);
    end else begin
      send_word(8'($urandom), 1'b1);
    end
  endtask

  task automatic test_valid_characters();
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hC2, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF4, 1'b0);
    send_word(8'h8F, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
  endtask

  task automatic test_malformed_input();
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hC1, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hED, 1'b0);
    send_word(8'hA0, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF4, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hE1, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h80, 1'b0);
  endtask

  task automatic test_end_of_stream();
    send_word(8'hF0, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_result_backpressure();
    long_hold_req = 1'b1;
    repeat (40) send_random_unit();
  endtask

  task automatic test_random_stream();
    while (words_sent < TotalWords) send_random_unit();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_valid_characters();
    test_malformed_input();
    test_end_of_stream();
    test_result_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("strict_utf8_decoder_top_test OK");
    end else begin
      $display("strict_utf8_decoder_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    int phase_left;
    int pct;
    phase_left = 0;
    pct = 100;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 75;
          2: pct = 40;
          default: pct = 10;
        endcase
      end
      phase_left--;
      out_ready <= ($urandom_range(1, 100) <= pct);
    end
  end

  always @(posedge clk) begin
    char_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result code_point=%0h status=%0d", $time, code_point, status);
        fail_count++;
      end else begin
        exp_r = expected_chars.pop_front();
        if (code_point !== exp_r.cp) begin
          $display("%0t: code_point expected %0h actual %0h", $time, exp_r.cp, code_point);
          fail_count++;
        end
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word accepted for %0d cycles", $time, IdleLimit);
      $display("strict_utf8_decoder_top_test NOT OK");
      $finish;
    end
  end

endmodule

// ===== strict_utf8_decoder_top.f =====
rtl/su8_pkg.sv
rtl/su8_front.sv
rtl/su8_queue.sv
rtl/su8_back.sv
rtl/strict_utf8_decoder_top.sv
tb/sv/strict_utf8_decoder_top_test.sv
